### src/fcrc_pkg.sv
// Shared widths, reset values and CRC constants for the fixed frame CRC-16 receiver.
`default_nettype none

package fcrc_pkg;

  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 5;
  localparam int CRC_W       = 16;
  localparam int CFG_INDEX_W = 1;

  localparam int FRAME_LEN_DEFAULT   = 18;
  localparam int CHECKED_LEN_DEFAULT = 15;

  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

  localparam logic [BYTE_W-1:0] ADDRESS_RESET  = 8'h01;
  localparam logic [BYTE_W-1:0] FUNCTION_RESET = 8'h03;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDRESS  = 1'b0,
    REG_FUNCTION = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

### src/fcrc_in_if.sv
// Input channel: one received byte per word.
`default_nettype none

interface fcrc_in_if;
  import fcrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/fcrc_out_if.sv
// Output channel: echoed byte with frame position and verdict flags.
`default_nettype none

interface fcrc_out_if;
  import fcrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic [INDEX_W-1:0] byte_index;
  logic               byte_kept;
  logic               frame_good;
  logic               frame_bad;

  modport source (output valid, output data_byte, output byte_index, output byte_kept,
                  output frame_good, output frame_bad, input ready);
  modport sink   (input valid, input data_byte, input byte_index, input byte_kept,
                  input frame_good, input frame_bad, output ready);
endinterface

`default_nettype wire

### src/fcrc_crc_step.sv
// Modbus CRC-16 update over one byte, unrolled over its eight bits.
`default_nettype none

module fcrc_crc_step (
  input  wire logic [fcrc_pkg::CRC_W-1:0]  crc_in,
  input  wire logic [fcrc_pkg::BYTE_W-1:0] data,
  output logic      [fcrc_pkg::CRC_W-1:0]  crc_out
);
  import fcrc_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### src/fixed_frame_crc16_receiver.sv
// Top level: fixed-length frame hunter with Modbus CRC-16 check.
//
//   channel | dir | word                                                   
//   in_ch   | in  | rx_byte                                                
//   out_ch  | out | data_byte, byte_index, byte_kept, frame_good, frame_bad 
//   cfg     | in  | cfg_wr_en, cfg_index, cfg_data (address, function)      
//
// One word in, one word out; a word is taken every cycle. Result appears the
// cycle after acceptance from the output register; the byte CRC update is
// the longest path. in_ch.ready drops only while a result is held by out_ch.
// Synchronous reset clears the hunt state and restores the register defaults.
`default_nettype none

module fixed_frame_crc16_receiver #(
  parameter int FRAME_LEN   = fcrc_pkg::FRAME_LEN_DEFAULT,
  parameter int CHECKED_LEN = fcrc_pkg::CHECKED_LEN_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [fcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fcrc_pkg::BYTE_W-1:0]      cfg_data,
  fcrc_in_if.sink                              in_ch,
  fcrc_out_if.source                           out_ch
);
  import fcrc_pkg::*;

  localparam int POS_W = $clog2(FRAME_LEN + 1);

  logic [BYTE_W-1:0] address_byte;
  logic [BYTE_W-1:0] function_byte;

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] crc_next;
  logic [CRC_W-1:0] crc_stepped;
  logic             match;
  logic             match_next;

  logic             kept;
  logic             good;
  logic             bad;
  logic             in_fire;
  logic [BYTE_W-1:0] b;
  int unsigned      pos;

  assign b       = in_ch.rx_byte;
  assign pos     = 32'(position);
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  fcrc_crc_step u_crc_step (
    .crc_in  (crc),
    .data    (b),
    .crc_out (crc_stepped)
  );

  always_comb begin
    position_next = position;
    crc_next      = crc;
    match_next    = match;
    kept          = 1'b1;
    good          = 1'b0;
    bad           = 1'b0;
    if (pos >= FRAME_LEN) begin
      kept          = 1'b0;
      position_next = '0;
      crc_next      = CRC_INIT;
      match_next    = 1'b0;
    end else begin
      if (pos == 0 && b != address_byte) begin
        kept = 1'b0;
      end
      if (pos == 1 && b != function_byte) begin
        kept = 1'b0;
      end
      if (!kept) begin
        position_next = '0;
        crc_next      = CRC_INIT;
        match_next    = 1'b0;
      end else begin
        if (pos < CHECKED_LEN) begin
          crc_next = crc_stepped;
        end else if (pos == CHECKED_LEN) begin
          match_next = (b == crc[BYTE_W-1:0]);
        end else if (pos == CHECKED_LEN + 1) begin
          match_next = match && (b == crc[CRC_W-1:BYTE_W]);
        end
        if (pos == FRAME_LEN - 1) begin
          if (match_next && (CHECKED_LEN + 1 < FRAME_LEN)) begin
            good          = 1'b1;
            position_next = '0;
            crc_next      = CRC_INIT;
            match_next    = 1'b0;
          end else begin
            bad           = 1'b1;
            position_next = POS_W'(FRAME_LEN);
          end
        end else begin
          position_next = position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte  <= ADDRESS_RESET;
      function_byte <= FUNCTION_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ADDRESS:  address_byte  <= cfg_data;
        REG_FUNCTION: function_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      crc          <= CRC_INIT;
      match        <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        position <= position_next;
        crc      <= crc_next;
        match    <= match_next;
      end
      out_ch.valid <= in_fire || (out_ch.valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.data_byte  <= b;
      out_ch.byte_index <= INDEX_W'(position);
      out_ch.byte_kept  <= kept;
      out_ch.frame_good <= good;
      out_ch.frame_bad  <= bad;
    end
  end

endmodule

`default_nettype wire

### sim/fixed_frame_crc16_receiver_tb.sv
// Self-checking testbench for the fixed frame CRC-16 receiver: framed and noisy byte traffic.
module fixed_frame_crc16_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcrc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               byte_kept;
    logic               frame_good;
    logic               frame_bad;
  } rx_word_t;

  class crc_frame_tracker;
    logic [BYTE_W-1:0] addr_match;
    logic [BYTE_W-1:0] func_match;
    int                hunt_pos;
    logic [CRC_W-1:0]  crc_acc;
    logic              crc_ok;
    rx_word_t          pending_words[$];
    int                mismatches;

    function new();
      addr_match = ADDRESS_RESET;
      func_match = FUNCTION_RESET;
      mismatches = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      hunt_pos = 0;
      crc_acc  = CRC_INIT;
      crc_ok   = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [BYTE_W-1:0] val);
      if (idx == REG_ADDRESS) addr_match = val;
      else func_match = val;
    endfunction

    function logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      int k;
      c = c ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] b);
      rx_word_t w;
      w.data_byte  = b;
      w.byte_index = INDEX_W'(hunt_pos);
      w.byte_kept  = 1'b1;
      w.frame_good = 1'b0;
      w.frame_bad  = 1'b0;
      if (hunt_pos >= FRAME_LEN_DEFAULT) begin
        // byte after a failed frame is dropped
        w.byte_index = INDEX_W'(FRAME_LEN_DEFAULT);
        w.byte_kept  = 1'b0;
        restart_hunt();
      end else begin
        if ((hunt_pos == 0 && b != addr_match) || (hunt_pos == 1 && b != func_match))
          w.byte_kept = 1'b0;
        if (!w.byte_kept) begin
          restart_hunt();
        end else begin
          if (hunt_pos < CHECKED_LEN_DEFAULT) crc_acc = crc_byte(crc_acc, b);
          else if (hunt_pos == CHECKED_LEN_DEFAULT) crc_ok = (b == crc_acc[7:0]);
          else if (hunt_pos == CHECKED_LEN_DEFAULT + 1) crc_ok = crc_ok && (b == crc_acc[15:8]);
          if (hunt_pos == FRAME_LEN_DEFAULT - 1) begin
            if (crc_ok && CHECKED_LEN_DEFAULT + 1 < FRAME_LEN_DEFAULT) begin
              w.frame_good = 1'b1;
              restart_hunt();
            end else begin
              w.frame_bad = 1'b1;
              hunt_pos = FRAME_LEN_DEFAULT;
            end
          end else begin
            hunt_pos = hunt_pos + 1;
          end
        end
      end
      pending_words.push_back(w);
    endfunction

    function void report(string field, logic [BYTE_W-1:0] exp, logic [BYTE_W-1:0] act);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp, act);
    endfunction

    function void check_out_word(rx_word_t act);
      rx_word_t exp;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected word, expected none actual %h", $time, act);
        return;
      end
      exp = pending_words.pop_front();
      if (act.data_byte !== exp.data_byte) report("data_byte", exp.data_byte, act.data_byte);
      if (act.byte_index !== exp.byte_index)
        report("byte_index", BYTE_W'(exp.byte_index), BYTE_W'(act.byte_index));
      if (act.byte_kept !== exp.byte_kept)
        report("byte_kept", BYTE_W'(exp.byte_kept), BYTE_W'(act.byte_kept));
      if (act.frame_good !== exp.frame_good)
        report("frame_good", BYTE_W'(exp.frame_good), BYTE_W'(act.frame_good));
      if (act.frame_bad !== exp.frame_bad)
        report("frame_bad", BYTE_W'(exp.frame_bad), BYTE_W'(act.frame_bad));
    endfunction
  endclass

  typedef enum {FR_GOOD, FR_BAD_LOW, FR_BAD_HIGH, FR_BAD_BOTH, FR_BAD_ADDR, FR_BAD_FUNC}
    frame_kind_t;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]      cfg_data;
  logic                   quiet = 1'b0;
  int                     cycles = 0;
  int                     bytes_sent = 0;
  crc_frame_tracker       trk = new();

  fcrc_in_if  in_ch();
  fcrc_out_if out_ch();

  fixed_frame_crc16_receiver uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      trk.check_out_word({out_ch.data_byte, out_ch.byte_index, out_ch.byte_kept,
                          out_ch.frame_good, out_ch.frame_bad});
  end

  // output back-pressure in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_rx_byte(logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    trk.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_kind_t kind, bit extremes);
    logic [BYTE_W-1:0] fr[FRAME_LEN_DEFAULT];
    logic [CRC_W-1:0]  c;
    int                n;
    fr[0] = trk.addr_match;
    fr[1] = trk.func_match;
    for (int i = 2; i < FRAME_LEN_DEFAULT; i++)
      fr[i] = extremes ? (i[0] ? 8'hFF : 8'h00) : BYTE_W'($urandom);
    c = CRC_INIT;
    for (int i = 0; i < CHECKED_LEN_DEFAULT; i++) c = trk.crc_byte(c, fr[i]);
    fr[CHECKED_LEN_DEFAULT]     = c[7:0];
    fr[CHECKED_LEN_DEFAULT + 1] = c[15:8];
    n = FRAME_LEN_DEFAULT;
    case (kind)
      FR_BAD_LOW: fr[CHECKED_LEN_DEFAULT] ^= BYTE_W'($urandom_range(1, 255));
      FR_BAD_HIGH: fr[CHECKED_LEN_DEFAULT + 1] ^= BYTE_W'($urandom_range(1, 255));
      FR_BAD_BOTH: begin
        fr[CHECKED_LEN_DEFAULT]     ^= BYTE_W'($urandom_range(1, 255));
        fr[CHECKED_LEN_DEFAULT + 1] ^= BYTE_W'($urandom_range(1, 255));
      end
      FR_BAD_ADDR: begin
        fr[0] ^= BYTE_W'($urandom_range(1, 255));
        n = 1;
      end
      FR_BAD_FUNC: begin
        fr[1] ^= BYTE_W'($urandom_range(1, 255));
        n = 2;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) send_rx_byte(fr[i]);
    // a failed frame swallows the following byte
    if (kind == FR_BAD_LOW || kind == FR_BAD_HIGH || kind == FR_BAD_BOTH)
      send_rx_byte(BYTE_W'($urandom));
  endtask

  task automatic wait_all_returned();
    in_ch.valid <= 1'b0;
    while (trk.pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_match_regs(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] f);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ADDRESS;
    cfg_data  <= a;
    @(posedge clk);
    trk.set_reg(REG_ADDRESS, a);
    cfg_index <= REG_FUNCTION;
    cfg_data  <= f;
    @(posedge clk);
    trk.set_reg(REG_FUNCTION, f);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int r;
    int target;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] f;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_ADDRESS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: header rejects, then a good frame of 00/FF payload
    send_rx_byte(8'hFF);
    send_rx_byte(8'h00);
    send_rx_byte(ADDRESS_RESET);
    send_rx_byte(8'hFF);
    send_frame(FR_GOOD, 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      wait_all_returned();
      case (ph)
        0: begin a = 8'h00; f = 8'hFF; end
        1: begin a = 8'hFF; f = 8'h00; end
        2: begin a = ADDRESS_RESET; f = FUNCTION_RESET; end
        default: begin a = BYTE_W'($urandom); f = BYTE_W'($urandom); end
      endcase
      write_match_regs(a, f);
      quiet  = (ph == 6);
      target = bytes_sent + 170;
      while (bytes_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) send_frame(FR_GOOD, 1'b0);
        else if (r < 67) send_frame(FR_BAD_LOW, 1'b0);
        else if (r < 73) send_frame(FR_BAD_HIGH, 1'b0);
        else if (r < 77) send_frame(FR_BAD_BOTH, 1'b0);
        else if (r < 83) send_frame(FR_BAD_ADDR, 1'b0);
        else if (r < 89) send_frame(FR_BAD_FUNC, 1'b0);
        else repeat ($urandom_range(1, 8)) send_rx_byte(BYTE_W'($urandom));
      end
    end

    wait_all_returned();
    repeat (4) @(posedge clk);
    if (trk.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
